[design/nnrc_pkg.sv]
`timescale 1ns / 1ps

package nnrc_pkg;

   // request kinds
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_PROCESS = 1'b1;

   // composition modes
   localparam logic [1:0] MODE_PUT  = 2'd0;
   localparam logic [1:0] MODE_OR   = 2'd1;
   localparam logic [1:0] MODE_AND  = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // pixel depth codes
   localparam logic DEPTH_1BIT = 1'b0;
   localparam logic DEPTH_8BIT = 1'b1;

   // control register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COS_NEG_ANGLE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIN_NEG_ANGLE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_X      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Y      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SRC_WIDTH     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SRC_HEIGHT    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPOSE_MODE  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_DEPTH   = 3'd7;
   localparam int CSR_DATA_WIDTH = 16;

   typedef struct packed {
      logic       req_type;
      logic [9:0] pos_x;
      logic [9:0] pos_y;
      logic [7:0] pixel_in;
   } nnrc_req_type;

   typedef struct packed {
      logic [7:0] new_pixel;
      logic       covered;
   } nnrc_rsp_type;

   typedef struct packed {
      logic signed [15:0] cos_neg_angle;
      logic signed [15:0] sin_neg_angle;
      logic [9:0]         center_x;
      logic [9:0]         center_y;
      logic [8:0]         src_width;
      logic [8:0]         src_height;
      logic [1:0]         compose_mode;
      logic               pixel_depth;
   } nnrc_cfg_type;

   // per-item control that follows the memory access
   typedef struct packed {
      logic       is_load;
      logic       hit;
      logic [7:0] pixel_in;
   } nnrc_ctl_type;

endpackage

[design/nearest_neighbor_rotate_compose_unit.sv]
`timescale 1ns / 1ps

// Nearest-neighbor rotate and compose. Load items (req_type 0) write one byte into the
// source pixel store of SRC_MAX_DIM x SRC_MAX_DIM entries; process items (req_type 1)
// return one result with the destination pixel after rotation and put/OR/AND composition.
// The block takes one item per clock when rsp_stall is low: a four-deep pipeline of
// input, product, sum and source-coordinate stages feeds one synchronous memory whose single
// read and single write port are both used at the same stage, so the throughput limit is
// that memory port. A process item's result passes the geometry, memory read and compose
// registers before it shows on rsp_valid. The source store has no reset; reading a pixel
// never loaded gives an unspecified value. The user must write control registers through
// csr_write_en, csr_index and csr_wdata only while no item is in flight (not enforced).
module nearest_neighbor_rotate_compose_unit #(
   parameter int SRC_MAX_DIM    = 256,
   parameter int DST_MAX_DIM    = 1024,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  nnrc_pkg::nnrc_req_type                  req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output nnrc_pkg::nnrc_rsp_type                  rsp_data,
   input  logic                                    csr_write_en,
   input  logic [nnrc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [nnrc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int DEPTH = SRC_MAX_DIM * SRC_MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   nnrc_pkg::nnrc_cfg_type cfg_ff, cfg_in;

   logic                   g_valid, g_stall;
   nnrc_pkg::nnrc_ctl_type g_ctl;
   logic [AW-1:0]          g_addr;
   logic                   m_valid, m_stall;
   nnrc_pkg::nnrc_ctl_type m_ctl;
   logic [7:0]             m_pixel;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            nnrc_pkg::CSR_COS_NEG_ANGLE: cfg_in.cos_neg_angle = $signed(csr_wdata);
            nnrc_pkg::CSR_SIN_NEG_ANGLE: cfg_in.sin_neg_angle = $signed(csr_wdata);
            nnrc_pkg::CSR_CENTER_X:      cfg_in.center_x      = csr_wdata[9:0];
            nnrc_pkg::CSR_CENTER_Y:      cfg_in.center_y      = csr_wdata[9:0];
            nnrc_pkg::CSR_SRC_WIDTH:     cfg_in.src_width     = csr_wdata[8:0];
            nnrc_pkg::CSR_SRC_HEIGHT:    cfg_in.src_height    = csr_wdata[8:0];
            nnrc_pkg::CSR_COMPOSE_MODE:  cfg_in.compose_mode  = csr_wdata[1:0];
            nnrc_pkg::CSR_PIXEL_DEPTH:   cfg_in.pixel_depth   = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_neg_angle <= 16'sd16384;
         cfg_ff.sin_neg_angle <= 16'sd0;
         cfg_ff.center_x      <= 10'd0;
         cfg_ff.center_y      <= 10'd0;
         cfg_ff.src_width     <= 9'd256;
         cfg_ff.src_height    <= 9'd256;
         cfg_ff.compose_mode  <= nnrc_pkg::MODE_PUT;
         cfg_ff.pixel_depth   <= nnrc_pkg::DEPTH_8BIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nnrc_geom #(
      .SRC_MAX_DIM    (SRC_MAX_DIM),
      .DST_MAX_DIM    (DST_MAX_DIM),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .AW             (AW)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (g_valid),
      .out_stall (g_stall),
      .out_ctl   (g_ctl),
      .out_addr  (g_addr)
   );

   nnrc_pix_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_stall  (g_stall),
      .in_ctl    (g_ctl),
      .in_addr   (g_addr),
      .out_valid (m_valid),
      .out_stall (m_stall),
      .out_ctl   (m_ctl),
      .out_pixel (m_pixel)
   );

   nnrc_compose u_compose (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (m_valid),
      .in_stall  (m_stall),
      .in_ctl    (m_ctl),
      .in_pixel  (m_pixel),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

[design/nnrc_geom.sv]
`timescale 1ns / 1ps

module nnrc_geom #(
   parameter int SRC_MAX_DIM    = 256,
   parameter int DST_MAX_DIM    = 1024,
   parameter int TRIG_FRAC_BITS = 14,
   parameter int AW             = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nnrc_pkg::nnrc_cfg_type cfg,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  nnrc_pkg::nnrc_req_type in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output nnrc_pkg::nnrc_ctl_type out_ctl,
   output logic [AW-1:0]         out_addr
);

   localparam int DW   = 11;
   localparam int PW   = 16 + DW;
   localparam int SW   = PW + 1;
   localparam int HPW  = 26;
   localparam int HW   = HPW + 1;
   localparam int QW   = SW - TRIG_FRAC_BITS + 1;
   localparam int XW   = ((QW > 10) ? QW : 10) + 1;
   localparam int CW   = $clog2(SRC_MAX_DIM);
   localparam int SDW0 = $clog2(SRC_MAX_DIM + 1);
   localparam int SDW  = (SDW0 > 9) ? SDW0 : 9;
   localparam int LW   = ((XW - 1) > SDW) ? (XW - 1) : SDW;
   localparam int DDW  = $clog2(DST_MAX_DIM + 1);
   localparam int PCW0 = (DDW > 10) ? DDW : 10;
   localparam int PCW  = (PCW0 > SDW0) ? PCW0 : SDW0;

   // stage valids and readiness
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rd1, rd2, rd3, rd4;

   nnrc_pkg::nnrc_req_type it1_ff, it2_ff, it3_ff, it4_ff;

   // stage 2: products
   logic signed [PW-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [PW-1:0] pcx_in, psy_in, psx_in, pcy_in;
   logic [HPW-1:0] ha1_ff, ha2_ff, ha3_ff, ha4_ff;
   logic [HPW-1:0] ha1_in, ha2_in, ha3_in, ha4_in;
   logic signed [DW-1:0] dx2_ff, dy2_ff, dx1, dy1;
   logic in_dst2_ff, in_dst2_in;

   // stage 3: sums and window test
   logic signed [SW-1:0] su3_ff, sv3_ff, su3_in, sv3_in;
   logic win3_ff, win3_in;

   // stage 4: source coordinate
   logic signed [XW-1:0] sx4_ff, sy4_ff, sx4_in, sy4_in;
   logic win4_ff, win4_in;

   // config-derived terms
   logic signed [16:0] ce, se;
   logic [16:0] abs_c, abs_s;
   logic [8:0]  sx0, sy0;
   logic [LW-1:0] w_sat, h_sat;

   logic [HW-1:0] hx, hy;
   logic [DW-1:0] adx, ady;
   logic [SW-1:0] au, av, qu, qv;
   logic signed [XW-1:0] tu, tv;
   logic [CW-1:0] rx, ry;
   logic hit;

   assign rd4 = !v4_ff || !out_stall;
   assign rd3 = !v3_ff || rd4;
   assign rd2 = !v2_ff || rd3;
   assign rd1 = !v1_ff || rd2;
   assign in_stall = !rd1;

   assign v1_in = rd1 ? in_valid : v1_ff;
   assign v2_in = rd2 ? v1_ff : v2_ff;
   assign v3_in = rd3 ? v2_ff : v3_ff;
   assign v4_in = rd4 ? v3_ff : v4_ff;

   always_comb begin
      ce    = 17'(cfg.cos_neg_angle);
      se    = 17'(cfg.sin_neg_angle);
      abs_c = ce[16] ? unsigned'(-ce) : unsigned'(ce);
      abs_s = se[16] ? unsigned'(-se) : unsigned'(se);
      sx0   = 9'((10'(cfg.src_width) + 10'd1) >> 1);
      sy0   = 9'((10'(cfg.src_height) + 10'd1) >> 1);
      w_sat = (LW'(cfg.src_width) > LW'(SRC_MAX_DIM)) ? LW'(SRC_MAX_DIM) : LW'(cfg.src_width);
      h_sat = (LW'(cfg.src_height) > LW'(SRC_MAX_DIM)) ? LW'(SRC_MAX_DIM)
                                                         : LW'(cfg.src_height);
   end

   // stage 1 to 2
   always_comb begin
      dx1 = $signed({1'b0, it1_ff.pos_x}) - $signed({1'b0, cfg.center_x});
      dy1 = $signed({1'b0, it1_ff.pos_y}) - $signed({1'b0, cfg.center_y});
      pcx_in = PW'(cfg.cos_neg_angle) * PW'(dx1);
      psy_in = PW'(cfg.sin_neg_angle) * PW'(dy1);
      psx_in = PW'(cfg.sin_neg_angle) * PW'(dx1);
      pcy_in = PW'(cfg.cos_neg_angle) * PW'(dy1);
      ha1_in = HPW'(sx0) * HPW'(abs_c);
      ha2_in = HPW'(sy0) * HPW'(abs_s);
      ha3_in = HPW'(sx0) * HPW'(abs_s);
      ha4_in = HPW'(sy0) * HPW'(abs_c);
      in_dst2_in = (PCW'(it1_ff.pos_x) < PCW'(DST_MAX_DIM)) &&
                   (PCW'(it1_ff.pos_y) < PCW'(DST_MAX_DIM));
   end

   // stage 2 to 3
   always_comb begin
      su3_in = SW'(pcx_ff) + SW'(psy_ff);
      sv3_in = SW'(psx_ff) - SW'(pcy_ff);
      hx  = (HW'(ha1_ff) + HW'(ha2_ff)) >> TRIG_FRAC_BITS;
      hy  = (HW'(ha3_ff) + HW'(ha4_ff)) >> TRIG_FRAC_BITS;
      adx = dx2_ff[DW-1] ? unsigned'(-dx2_ff) : unsigned'(dx2_ff);
      ady = dy2_ff[DW-1] ? unsigned'(-dy2_ff) : unsigned'(dy2_ff);
      win3_in = in_dst2_ff && (HW'(adx) <= hx) && (HW'(ady) <= hy) &&
                (cfg.compose_mode != nnrc_pkg::MODE_NONE);
   end

   // stage 3 to 4: truncate toward zero and offset by the source centre
   always_comb begin
      au = su3_ff[SW-1] ? unsigned'(-su3_ff) : unsigned'(su3_ff);
      av = sv3_ff[SW-1] ? unsigned'(-sv3_ff) : unsigned'(sv3_ff);
      qu = au >> TRIG_FRAC_BITS;
      qv = av >> TRIG_FRAC_BITS;
      tu = su3_ff[SW-1] ? -$signed(XW'(qu)) : $signed(XW'(qu));
      tv = sv3_ff[SW-1] ? -$signed(XW'(qv)) : $signed(XW'(qv));
      sx4_in = $signed(XW'(sx0)) + tu;
      sy4_in = $signed(XW'(sy0)) - tv;
      win4_in = win3_ff;
   end

   // stage 4: range check and memory address
   always_comb begin
      if (it4_ff.req_type == nnrc_pkg::REQ_LOAD) begin
         hit = (PCW'(it4_ff.pos_x) < PCW'(SRC_MAX_DIM)) &&
               (PCW'(it4_ff.pos_y) < PCW'(SRC_MAX_DIM));
         rx  = CW'(it4_ff.pos_x);
         ry  = CW'(it4_ff.pos_y);
      end else begin
         hit = win4_ff && !sx4_ff[XW-1] && !sy4_ff[XW-1] &&
               (LW'(sx4_ff[XW-2:0]) < w_sat) && (LW'(sy4_ff[XW-2:0]) < h_sat);
         rx  = CW'(sx4_ff[XW-2:0]);
         ry  = CW'(sy4_ff[XW-2:0]);
      end
      out_addr = AW'(ry) * AW'(SRC_MAX_DIM) + AW'(rx);
      out_ctl.is_load  = (it4_ff.req_type == nnrc_pkg::REQ_LOAD);
      out_ctl.hit      = hit;
      out_ctl.pixel_in = it4_ff.pixel_in;
   end

   assign out_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd1) begin
         it1_ff <= in_data;
      end
      if (rd2) begin
         it2_ff     <= it1_ff;
         pcx_ff     <= pcx_in;
         psy_ff     <= psy_in;
         psx_ff     <= psx_in;
         pcy_ff     <= pcy_in;
         ha1_ff     <= ha1_in;
         ha2_ff     <= ha2_in;
         ha3_ff     <= ha3_in;
         ha4_ff     <= ha4_in;
         dx2_ff     <= dx1;
         dy2_ff     <= dy1;
         in_dst2_ff <= in_dst2_in;
      end
      if (rd3) begin
         it3_ff  <= it2_ff;
         su3_ff  <= su3_in;
         sv3_ff  <= sv3_in;
         win3_ff <= win3_in;
      end
      if (rd4) begin
         it4_ff  <= it3_ff;
         sx4_ff  <= sx4_in;
         sy4_ff  <= sy4_in;
         win4_ff <= win4_in;
      end
   end

endmodule

[design/nnrc_pix_mem.sv]
`timescale 1ns / 1ps

module nnrc_pix_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  nnrc_pkg::nnrc_ctl_type in_ctl,
   input  logic [AW-1:0]         in_addr,
   output logic                  out_valid,
   input  logic                  out_stall,
   output nnrc_pkg::nnrc_ctl_type out_ctl,
   output logic [7:0]            out_pixel
);

   logic [7:0] mem [DEPTH];

   logic valid_ff, valid_in;
   nnrc_pkg::nnrc_ctl_type ctl_ff;
   logic [7:0] rdata_ff;
   logic accept;

   assign in_stall = valid_ff && out_stall;
   assign accept   = in_valid && !in_stall;
   // load items end here and leave no result
   assign valid_in = in_stall ? valid_ff : (in_valid && !in_ctl.is_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_ctl.is_load && in_ctl.hit) begin
         mem[in_addr] <= in_ctl.pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !in_ctl.is_load && in_ctl.hit) begin
         rdata_ff <= mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_pixel = rdata_ff;

endmodule

[design/nnrc_compose.sv]
`timescale 1ns / 1ps

module nnrc_compose (
   input  logic                  clock,
   input  logic                  reset,
   input  nnrc_pkg::nnrc_cfg_type cfg,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  nnrc_pkg::nnrc_ctl_type in_ctl,
   input  logic [7:0]            in_pixel,
   output logic                  out_valid,
   input  logic                  out_stall,
   output nnrc_pkg::nnrc_rsp_type out_data
);

   logic valid_ff, valid_in;
   nnrc_pkg::nnrc_rsp_type data_ff, data_in;
   logic [7:0] old_px, src_px;

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_comb begin
      if (cfg.pixel_depth == nnrc_pkg::DEPTH_8BIT) begin
         old_px = in_ctl.pixel_in;
         src_px = in_pixel;
      end else begin
         old_px = {7'd0, in_ctl.pixel_in[0]};
         src_px = {7'd0, in_pixel[0]};
      end
      data_in.covered   = in_ctl.hit;
      data_in.new_pixel = old_px;
      if (in_ctl.hit) begin
         case (cfg.compose_mode)
            nnrc_pkg::MODE_PUT: data_in.new_pixel = src_px;
            nnrc_pkg::MODE_OR:  data_in.new_pixel = old_px | src_px;
            nnrc_pkg::MODE_AND: data_in.new_pixel = old_px & src_px;
            default:            data_in.new_pixel = old_px;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sim/tb_nearest_neighbor_rotate_compose_unit.sv]
`timescale 1ns / 1ps

module tb_nearest_neighbor_rotate_compose_unit;

   localparam int SRC_DIM        = 256;
   localparam int SRC_CELLS      = SRC_DIM * SRC_DIM;
   localparam int FRAC_BITS      = 14;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 11;
   localparam int PHASE_ITEMS    = 85;

   class rotate_compose_scoreboard;
      nnrc_pkg::nnrc_cfg_type cfg;
      logic [7:0]             src_pixel [SRC_CELLS];
      bit                     src_loaded [SRC_CELLS];
      nnrc_pkg::nnrc_rsp_type expected_pixels [$];
      int                     errors;

      function new();
         cfg.cos_neg_angle = 16'sd16384;
         cfg.sin_neg_angle = 16'sd0;
         cfg.center_x      = '0;
         cfg.center_y      = '0;
         cfg.src_width     = 9'd256;
         cfg.src_height    = 9'd256;
         cfg.compose_mode  = nnrc_pkg::MODE_PUT;
         cfg.pixel_depth   = nnrc_pkg::DEPTH_8BIT;
         errors            = 0;
      endfunction

      function void write_reg(logic [nnrc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              logic [nnrc_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            nnrc_pkg::CSR_COS_NEG_ANGLE: cfg.cos_neg_angle = data;
            nnrc_pkg::CSR_SIN_NEG_ANGLE: cfg.sin_neg_angle = data;
            nnrc_pkg::CSR_CENTER_X:      cfg.center_x      = data[9:0];
            nnrc_pkg::CSR_CENTER_Y:      cfg.center_y      = data[9:0];
            nnrc_pkg::CSR_SRC_WIDTH:     cfg.src_width     = data[8:0];
            nnrc_pkg::CSR_SRC_HEIGHT:    cfg.src_height    = data[8:0];
            nnrc_pkg::CSR_COMPOSE_MODE:  cfg.compose_mode  = data[1:0];
            nnrc_pkg::CSR_PIXEL_DEPTH:   cfg.pixel_depth   = data[0];
            default: ;
         endcase
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // divide by the trig scale, rounding toward zero
      function longint trunc_frac(longint v);
         return (v < 0) ? -((-v) >> FRAC_BITS) : (v >> FRAC_BITS);
      endfunction

      function void window_half_extents(output longint hx, output longint hy);
         longint c, s, sx0, sy0;
         c   = longint'($signed(cfg.cos_neg_angle));
         s   = longint'($signed(cfg.sin_neg_angle));
         sx0 = (longint'(cfg.src_width) + 1) / 2;
         sy0 = (longint'(cfg.src_height) + 1) / 2;
         hx  = (sx0 * mag(c) + sy0 * mag(s)) >> FRAC_BITS;
         hy  = (sx0 * mag(s) + sy0 * mag(c)) >> FRAC_BITS;
      endfunction

      // 1 when a process item composes from the store, addr tells which entry
      function bit map_to_source(nnrc_pkg::nnrc_req_type r, output int addr);
         longint hx, hy, c, s, w, h, sx0, sy0, dx, dy, sx, sy;
         addr = 0;
         window_half_extents(hx, hy);
         c   = longint'($signed(cfg.cos_neg_angle));
         s   = longint'($signed(cfg.sin_neg_angle));
         w   = longint'(cfg.src_width);
         h   = longint'(cfg.src_height);
         sx0 = (w + 1) / 2;
         sy0 = (h + 1) / 2;
         if (w > SRC_DIM) w = SRC_DIM;
         if (h > SRC_DIM) h = SRC_DIM;
         dx = longint'(r.pos_x) - longint'(cfg.center_x);
         dy = longint'(r.pos_y) - longint'(cfg.center_y);
         if (mag(dx) > hx || mag(dy) > hy || cfg.compose_mode == nnrc_pkg::MODE_NONE)
            return 0;
         sx = sx0 + trunc_frac(c * dx + s * dy);
         sy = sy0 - trunc_frac(s * dx - c * dy);
         if (sx < 0 || sx >= w || sy < 0 || sy >= h) return 0;
         addr = int'(sy * SRC_DIM + sx);
         return 1;
      endfunction

      function void note_item(nnrc_pkg::nnrc_req_type r);
         nnrc_pkg::nnrc_rsp_type rsp;
         logic [7:0]             old_val, src;
         int                     addr;
         if (r.req_type == nnrc_pkg::REQ_LOAD) begin
            if (r.pos_x < SRC_DIM && r.pos_y < SRC_DIM) begin
               src_pixel[r.pos_y * SRC_DIM + r.pos_x]  = r.pixel_in;
               src_loaded[r.pos_y * SRC_DIM + r.pos_x] = 1'b1;
            end
            return;
         end
         old_val       = (cfg.pixel_depth == nnrc_pkg::DEPTH_8BIT) ? r.pixel_in
                                                                   : {7'b0, r.pixel_in[0]};
         rsp.new_pixel = old_val;
         rsp.covered   = 1'b0;
         if (map_to_source(r, addr)) begin
            src = src_pixel[addr];
            if (cfg.pixel_depth == nnrc_pkg::DEPTH_1BIT) src = {7'b0, src[0]};
            case (cfg.compose_mode)
               nnrc_pkg::MODE_PUT: rsp.new_pixel = src;
               nnrc_pkg::MODE_OR:  rsp.new_pixel = old_val | src;
               default:            rsp.new_pixel = old_val & src;
            endcase
            rsp.covered = 1'b1;
         end
         expected_pixels.push_back(rsp);
      endfunction

      function void check_result(nnrc_pkg::nnrc_rsp_type got);
         nnrc_pkg::nnrc_rsp_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual new_pixel=%h covered=%b",
                     $time, got.new_pixel, got.covered);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.new_pixel !== want.new_pixel) begin
            $display("%0t: new_pixel mismatch: expected %h, actual %h",
                     $time, want.new_pixel, got.new_pixel);
            errors++;
         end
         if (got.covered !== want.covered) begin
            $display("%0t: covered mismatch: expected %b, actual %b",
                     $time, want.covered, got.covered);
            errors++;
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   nnrc_pkg::nnrc_req_type               req_data;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   nnrc_pkg::nnrc_rsp_type               rsp_data;
   logic                                 csr_write_en;
   logic [nnrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [nnrc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   rotate_compose_scoreboard sb = new();

   int burst_left = 1;
   int stall_left = 0;
   bit stall_now  = 1'b0;
   int quiet      = 0;

   nearest_neighbor_rotate_compose_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   // receiver: runs of stall and free cycles, now and then a long free stretch
   always @(negedge clock) begin
      int pick;
      if (stall_left == 0) begin
         pick       = $urandom_range(0, 7);
         stall_now  = (pick >= 5);
         stall_left = (pick == 0) ? $urandom_range(20, 60) : $urandom_range(1, stall_now ? 10 : 6);
      end else begin
         stall_left--;
      end
      rsp_stall <= stall_now;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic nnrc_pkg::nnrc_req_type make_item(logic kind, int x, int y, int v);
      nnrc_pkg::nnrc_req_type r;
      r.req_type = kind;
      r.pos_x    = 10'(x);
      r.pos_y    = 10'(y);
      r.pixel_in = 8'(v);
      return r;
   endfunction

   function automatic nnrc_pkg::nnrc_cfg_type make_cfg(int cs, int sn, int cx, int cy,
                                                       int w, int h,
                                                       logic [1:0] mode, logic depth);
      nnrc_pkg::nnrc_cfg_type m;
      m.cos_neg_angle = 16'(cs);
      m.sin_neg_angle = 16'(sn);
      m.center_x      = 10'(cx);
      m.center_y      = 10'(cy);
      m.src_width     = 9'(w);
      m.src_height    = 9'(h);
      m.compose_mode  = mode;
      m.pixel_depth   = depth;
      return m;
   endfunction

   function automatic int pick_trig();
      case ($urandom_range(0, 5))
         0: return ($urandom_range(0, 1) ? 16384 : -16384);
         1: return int'($signed(16'($urandom)));
         2: return 0;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 0;
               1: return 1;
               2: return 256;
               default: return 511;
            endcase
         1: return $urandom_range(257, 511);
         2, 3: return $urandom_range(41, 256);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   function automatic int pick_center();
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 1023 : 0;
      return $urandom_range(0, 1023);
   endfunction

   function automatic nnrc_pkg::nnrc_cfg_type random_cfg();
      logic [1:0] mode;
      case ($urandom_range(0, 7))
         0, 1, 2: mode = nnrc_pkg::MODE_PUT;
         3, 4:    mode = nnrc_pkg::MODE_OR;
         5, 6:    mode = nnrc_pkg::MODE_AND;
         default: mode = nnrc_pkg::MODE_NONE;
      endcase
      return make_cfg(pick_trig(), pick_trig(), pick_center(), pick_center(),
                      pick_dim(), pick_dim(), mode,
                      $urandom_range(0, 1) ? nnrc_pkg::DEPTH_8BIT : nnrc_pkg::DEPTH_1BIT);
   endfunction

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send(nnrc_pkg::nnrc_req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 16));
      end
   endtask

   // a process item that would read a never-loaded entry gets that entry loaded first
   task automatic issue(nnrc_pkg::nnrc_req_type r);
      int addr;
      if (r.req_type == nnrc_pkg::REQ_PROCESS && sb.map_to_source(r, addr) &&
          !sb.src_loaded[addr])
         send(make_item(nnrc_pkg::REQ_LOAD, addr % SRC_DIM, addr / SRC_DIM,
                        $urandom_range(0, 255)));
      send(r);
   endtask

   task automatic drain();
      idle_sender(0);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic program_reg(logic [nnrc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              logic [nnrc_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_config(nnrc_pkg::nnrc_cfg_type m);
      drain();
      // load items leave no result behind, let them clear the pipeline
      repeat (8) @(posedge clock);
      program_reg(nnrc_pkg::CSR_COS_NEG_ANGLE, m.cos_neg_angle);
      program_reg(nnrc_pkg::CSR_SIN_NEG_ANGLE, m.sin_neg_angle);
      program_reg(nnrc_pkg::CSR_CENTER_X, 16'(m.center_x));
      program_reg(nnrc_pkg::CSR_CENTER_Y, 16'(m.center_y));
      program_reg(nnrc_pkg::CSR_SRC_WIDTH, 16'(m.src_width));
      program_reg(nnrc_pkg::CSR_SRC_HEIGHT, 16'(m.src_height));
      program_reg(nnrc_pkg::CSR_COMPOSE_MODE, 16'(m.compose_mode));
      program_reg(nnrc_pkg::CSR_PIXEL_DEPTH, 16'(m.pixel_depth));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      nnrc_pkg::nnrc_cfg_type base, m;
      logic [1:0]             modes [3];
      modes = '{nnrc_pkg::MODE_OR, nnrc_pkg::MODE_AND, nnrc_pkg::MODE_NONE};
      // identity mapping: source centre sits on (128,128)
      base = make_cfg(16384, 0, 128, 128, 256, 256, nnrc_pkg::MODE_PUT, nnrc_pkg::DEPTH_8BIT);
      apply_config(base);
      issue(make_item(nnrc_pkg::REQ_LOAD, 0, 0, 8'hff));
      issue(make_item(nnrc_pkg::REQ_LOAD, 255, 0, 8'h00));
      issue(make_item(nnrc_pkg::REQ_LOAD, 0, 255, 8'ha5));
      issue(make_item(nnrc_pkg::REQ_LOAD, 255, 255, 8'h5a));
      // loads beyond the store are dropped
      issue(make_item(nnrc_pkg::REQ_LOAD, 1023, 1023, 8'h11));
      issue(make_item(nnrc_pkg::REQ_LOAD, 256, 7, 8'h22));
      issue(make_item(nnrc_pkg::REQ_LOAD, 7, 256, 8'h33));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 0, 0, 8'h00));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 255, 255, 8'hff));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 256, 128, 8'h3c));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 128, 256, 8'hc3));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 1023, 1023, 8'hc3));
      foreach (modes[i]) begin
         m = base;
         m.compose_mode = modes[i];
         apply_config(m);
         issue(make_item(nnrc_pkg::REQ_PROCESS, 0, 0, 8'h5a));
         issue(make_item(nnrc_pkg::REQ_PROCESS, 255, 255, 8'h5a));
      end
      m = base;
      m.compose_mode = nnrc_pkg::MODE_OR;
      m.pixel_depth  = nnrc_pkg::DEPTH_1BIT;
      apply_config(m);
      issue(make_item(nnrc_pkg::REQ_PROCESS, 0, 255, 8'hfe));
      issue(make_item(nnrc_pkg::REQ_PROCESS, 1023, 0, 8'hff));
      // oversized source saturates to the store size
      m = base;
      m.src_width  = 9'd511;
      m.src_height = 9'd300;
      apply_config(m);
      issue(make_item(nnrc_pkg::REQ_PROCESS, 100, 128, 8'h81));
      m = base;
      m.src_width = 9'd0;
      apply_config(m);
      issue(make_item(nnrc_pkg::REQ_PROCESS, 128, 128, 8'h77));
   endtask

   task automatic run_random_phase(int phase);
      longint hx, hy;
      int     pick, x, y, dx, dy;
      if (phase == 0)
         apply_config(make_cfg(-32768, 32767, 1023, 1023, 511, 511, nnrc_pkg::MODE_AND,
                               nnrc_pkg::DEPTH_1BIT));
      else if (phase == 1)
         apply_config(make_cfg(-16384, -16384, 0, 0, 1, 1, nnrc_pkg::MODE_PUT,
                               nnrc_pkg::DEPTH_8BIT));
      else
         apply_config(random_cfg());
      sb.window_half_extents(hx, hy);
      if (hx > 520) hx = 520;
      if (hy > 520) hy = 520;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (phase == 3 && n == 40) drain();
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            x = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 255);
            y = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 255);
            issue(make_item(nnrc_pkg::REQ_LOAD, x, y, $urandom_range(0, 255)));
         end else if (pick < 30) begin
            issue(make_item(nnrc_pkg::REQ_PROCESS, $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 255)));
         end else begin
            // mostly around the rotated window, a little past its edge
            dx = int'($urandom_range(0, 2 * int'(hx) + 4)) - int'(hx) - 2;
            dy = int'($urandom_range(0, 2 * int'(hy) + 4)) - int'(hy) - 2;
            x  = (int'(sb.cfg.center_x) + dx) & 1023;
            y  = (int'(sb.cfg.center_y) + dy) & 1023;
            issue(make_item(nnrc_pkg::REQ_PROCESS, x, y, $urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = nnrc_pkg::CSR_COS_NEG_ANGLE;
      csr_wdata    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);
      drain();
      repeat (12) @(posedge clock);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
